// ----- sv/assert_macros.svh -----
// assertion helpers included by the rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- sv/mpi_pkg.sv -----
package mpi_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_GCD,
      ST_MUL_DBL,
      ST_MUL_ADD,
      ST_DONE
   } state_type;

endpackage

// ----- sv/modular_power_and_inverse_unit.sv -----
// power mode: one remainder pass reduces the base, then each exponent bit takes one or two modular products,
//   each product one double step per multiplier bit plus one add step per set multiplier bit
// inverse mode adds one remainder pass per euclid remainder step (at most about 45 steps)
// one transaction at a time: busy stays high until the result strobe has gone out;
//   every step above runs on the single add and conditional-subtract unit
// reset: synchronous active high, returns to idle; the result strobe cannot be stalled
`include "assert_macros.svh"

module modular_power_and_inverse_unit #(
   parameter int MOD_BITS = 31,
   parameter int EXP_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_func,
   input  logic [MOD_BITS-1:0] req_base,
   input  logic [EXP_BITS-1:0] req_exponent,
   input  logic [MOD_BITS-1:0] req_modulus,
   output logic                rsp_valid,
   output logic [MOD_BITS-1:0] rsp_value,
   output logic                rsp_no_inverse
);

   localparam int CNT_W = $clog2(MOD_BITS + 1);
   localparam int ECNT_W = $clog2(EXP_BITS + 1);
   localparam int WIDE = (MOD_BITS > EXP_BITS) ? MOD_BITS : EXP_BITS;

   mpi_pkg::state_type state_ff, state_in;

   logic                func_ff, func_in;
   logic                flag_ff, flag_in;
   logic                sq_ff, sq_in;
   logic [MOD_BITS-1:0] mod_ff, mod_in;
   logic [MOD_BITS-1:0] div_ff, div_in;
   logic [MOD_BITS-1:0] acc_ff, acc_in;
   logic [MOD_BITS-1:0] mplr_ff, mplr_in;
   logic [MOD_BITS-1:0] mcand_ff, mcand_in;
   logic [MOD_BITS-1:0] red_ff, red_in;
   logic [MOD_BITS-1:0] res_ff, res_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ECNT_W-1:0]   ecnt_ff, ecnt_in;

   // shared unit: (x + y + cin) reduced once by div_ff
   logic [MOD_BITS-1:0] unit_x, unit_y, unit_res;
   logic                unit_cin;
   logic [MOD_BITS:0]   unit_sum;
   logic [MOD_BITS+1:0] unit_diff;

   assign unit_sum  = {1'b0, unit_x} + {1'b0, unit_y} + {{MOD_BITS{1'b0}}, unit_cin};
   assign unit_diff = {1'b0, unit_sum} - {2'b00, div_ff};
   assign unit_res  = unit_diff[MOD_BITS+1] ? unit_sum[MOD_BITS-1:0]
                                            : unit_diff[MOD_BITS-1:0];

   logic                step_last;
   logic                bit_done;
   logic                pow_last;
   logic [WIDE-1:0]     inv_exp_wide;
   logic [EXP_BITS-1:0] inv_exp;

   assign step_last    = (cnt_ff == CNT_W'(1));
   assign bit_done     = !(sq_ff && exp_ff[EXP_BITS-1]);
   assign pow_last     = bit_done && (ecnt_ff == ECNT_W'(1));
   assign inv_exp_wide = WIDE'(mod_ff) - WIDE'(2);
   assign inv_exp      = inv_exp_wide[EXP_BITS-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpi_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_modulus < MOD_BITS'(2)) ? mpi_pkg::ST_DONE
                                                       : mpi_pkg::ST_REDUCE;
            end
         end
         mpi_pkg::ST_REDUCE: begin
            if (step_last) begin
               if (!func_ff) begin
                  state_in = mpi_pkg::ST_MUL_DBL;
               end else begin
                  state_in = (unit_res == '0) ? mpi_pkg::ST_DONE : mpi_pkg::ST_GCD;
               end
            end
         end
         mpi_pkg::ST_GCD: begin
            if (step_last && unit_res == '0) begin
               state_in = (div_ff == MOD_BITS'(1)) ? mpi_pkg::ST_MUL_DBL
                                                   : mpi_pkg::ST_DONE;
            end
         end
         mpi_pkg::ST_MUL_DBL: begin
            if (mplr_ff[MOD_BITS-1]) begin
               state_in = mpi_pkg::ST_MUL_ADD;
            end else if (step_last && pow_last) begin
               state_in = mpi_pkg::ST_DONE;
            end
         end
         mpi_pkg::ST_MUL_ADD: begin
            state_in = (step_last && pow_last) ? mpi_pkg::ST_DONE : mpi_pkg::ST_MUL_DBL;
         end
         mpi_pkg::ST_DONE: begin
            state_in = mpi_pkg::ST_IDLE;
         end
         default: begin
            state_in = mpi_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy      = (state_ff != mpi_pkg::ST_IDLE);
      rsp_valid = (state_ff == mpi_pkg::ST_DONE);
   end

   assign rsp_value      = res_ff;
   assign rsp_no_inverse = flag_ff;

   // datapath
   always_comb begin
      logic                start_pow;
      logic [EXP_BITS-1:0] pow_exp;
      logic                mul_done;

      start_pow = 1'b0;
      pow_exp   = exp_ff;
      mul_done  = 1'b0;

      func_in  = func_ff;
      flag_in  = flag_ff;
      sq_in    = sq_ff;
      mod_in   = mod_ff;
      div_in   = div_ff;
      acc_in   = acc_ff;
      mplr_in  = mplr_ff;
      mcand_in = mcand_ff;
      red_in   = red_ff;
      res_in   = res_ff;
      exp_in   = exp_ff;
      cnt_in   = cnt_ff;
      ecnt_in  = ecnt_ff;

      unit_x   = acc_ff;
      unit_y   = acc_ff;
      unit_cin = 1'b0;

      unique case (state_ff)
         mpi_pkg::ST_IDLE: begin
            if (start) begin
               func_in = req_func;
               mod_in  = req_modulus;
               exp_in  = req_exponent;
               div_in  = req_modulus;
               acc_in  = '0;
               mplr_in = req_base;
               cnt_in  = CNT_W'(MOD_BITS);
               res_in  = '0;
               // modulus below two answers at once
               flag_in = (req_modulus < MOD_BITS'(2)) ? req_func : 1'b0;
            end
         end
         mpi_pkg::ST_REDUCE, mpi_pkg::ST_GCD: begin
            // restoring remainder step, dividend enters from the top of mplr
            unit_cin = mplr_ff[MOD_BITS-1];
            acc_in   = unit_res;
            mplr_in  = mplr_ff << 1;
            cnt_in   = cnt_ff - CNT_W'(1);
            if (step_last) begin
               acc_in = '0;
               cnt_in = CNT_W'(MOD_BITS);
               if (state_ff == mpi_pkg::ST_REDUCE) begin
                  red_in = unit_res;
                  if (!func_ff) begin
                     start_pow = 1'b1;
                  end else if (unit_res == '0) begin
                     flag_in = 1'b1;
                  end else begin
                     div_in  = unit_res;
                     mplr_in = mod_ff;
                  end
               end else if (unit_res == '0) begin
                  // gcd is the last divisor
                  if (div_ff == MOD_BITS'(1)) begin
                     start_pow = 1'b1;
                     pow_exp   = inv_exp;
                  end else begin
                     flag_in = 1'b1;
                  end
               end else begin
                  mplr_in = div_ff;
                  div_in  = unit_res;
               end
            end
         end
         mpi_pkg::ST_MUL_DBL: begin
            acc_in = unit_res;
            if (!mplr_ff[MOD_BITS-1]) begin
               mplr_in  = mplr_ff << 1;
               cnt_in   = cnt_ff - CNT_W'(1);
               mul_done = step_last;
            end
         end
         mpi_pkg::ST_MUL_ADD: begin
            unit_y   = mcand_ff;
            acc_in   = unit_res;
            mplr_in  = mplr_ff << 1;
            cnt_in   = cnt_ff - CNT_W'(1);
            mul_done = step_last;
         end
         mpi_pkg::ST_DONE: begin
         end
         default: begin
         end
      endcase

      if (start_pow) begin
         res_in   = MOD_BITS'(1);
         exp_in   = pow_exp;
         ecnt_in  = ECNT_W'(EXP_BITS);
         div_in   = mod_ff;
         mcand_in = MOD_BITS'(1);
         mplr_in  = MOD_BITS'(1);
         acc_in   = '0;
         cnt_in   = CNT_W'(MOD_BITS);
         sq_in    = 1'b1;
      end

      if (mul_done) begin
         res_in = unit_res;
         acc_in = '0;
         cnt_in = CNT_W'(MOD_BITS);
         if (!bit_done) begin
            // square done and exponent bit set: multiply by the reduced base
            mcand_in = unit_res;
            mplr_in  = red_ff;
            sq_in    = 1'b0;
         end else begin
            exp_in   = exp_ff << 1;
            ecnt_in  = ecnt_ff - ECNT_W'(1);
            mcand_in = unit_res;
            mplr_in  = unit_res;
            sq_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mpi_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      func_ff  <= func_in;
      flag_ff  <= flag_in;
      sq_ff    <= sq_in;
      mod_ff   <= mod_in;
      div_ff   <= div_in;
      acc_ff   <= acc_in;
      mplr_ff  <= mplr_in;
      mcand_ff <= mcand_in;
      red_ff   <= red_in;
      res_ff   <= res_in;
      exp_ff   <= exp_in;
      cnt_ff   <= cnt_in;
      ecnt_ff  <= ecnt_in;
   end

   `ASSERT_NEXT(a_strobe_one_cycle, clock, reset, rsp_valid, !rsp_valid)
   `ASSERT_IMPLIES(a_no_inverse_zero, clock, reset, rsp_valid && rsp_no_inverse, rsp_value == '0)
   `ASSERT_IMPLIES(a_power_no_flag, clock, reset, rsp_valid && !func_ff, !rsp_no_inverse)
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_acc_reduced, clock, reset,
      state_ff == mpi_pkg::ST_MUL_DBL || state_ff == mpi_pkg::ST_MUL_ADD, acc_ff < div_ff)

endmodule
